[hdl/bpe_pkg.sv]
`timescale 1ns / 1ps

package bpe_pkg;

    // Field widths of the coordinate and parameter formats.
    localparam int COORD_W   = 24;
    localparam int FRAC_BITS = 16;

    // Derived datapath widths.
    localparam int T_W     = FRAC_BITS + 1;
    localparam int PT_W    = COORD_W + 1;
    localparam int SQ_W    = 2 * FRAC_BITS + 1;
    localparam int CB_W    = 3 * FRAC_BITS + 1;
    localparam int W_W     = 3 * FRAC_BITS + 1;
    localparam int W_LO    = W_W / 2;
    localparam int W_HI    = W_W - W_LO;
    localparam int LO_PW   = PT_W + W_LO + 1;
    localparam int HI_PW   = PT_W + W_HI + 1;
    localparam int TERM_W  = PT_W + W_W;
    localparam int ACC_W   = TERM_W + 1;
    localparam int SHIFT   = 3 * FRAC_BITS;
    localparam int RES_W   = ACC_W - SHIFT;
    localparam int NSTAGES = 9;

    localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (SHIFT - 1);
    localparam logic [W_W+1:0] W_SUM = (W_W + 2)'(1) << SHIFT;
    localparam logic signed [RES_W-1:0] RES_MAX = RES_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
    localparam logic signed [RES_W-1:0] RES_MIN = -RES_MAX - RES_W'(1);

    // Curve order codes as carried in the command field.
    localparam logic [1:0] CMD_LINEAR = 2'd0;
    localparam logic [1:0] CMD_QUAD   = 2'd1;
    localparam logic [1:0] CMD_CUBIC  = 2'd2;

    typedef enum logic [1:0] {
        ORD_LINEAR,
        ORD_QUAD,
        ORD_CUBIC
    } t_order;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] out_dx;
        logic signed [COORD_W-1:0] out_dy;
        logic signed [COORD_W-1:0] in_dx;
        logic signed [COORD_W-1:0] in_dy;
        logic [T_W-1:0]            curve_param;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      clipped;
    } t_out_word;

endpackage

[hdl/bezier_point_eval_unit.sv]
// Bezier point evaluator: each input word carries a linear, quadratic or cubic
// 2-D segment and a parameter t, and one output word returns the point on the
// segment at t, rounded to nearest and saturated to Q15.8, with clipped set if
// either axis saturated. The datapath is a nine-stage pipeline that takes one
// word per clock unless every stage is full and the output stalls. Its stages:
// one stage that clamps t and forms the control points, two stages of powers
// of t and 1-t, one stage forming the Bernstein weights, one stage of split
// products of at most 25x26 bits, three stages of exact accumulation, and one
// stage of rounding and saturation. Each stage only holds when the stage after
// it is full and stalled, so empty slots are squeezed out and the input stays
// ready while a finished word waits at the output, until every stage is full.
`timescale 1ns / 1ps

module bezier_point_eval_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bpe_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bpe_pkg::t_out_word o_out_word
);

    localparam int NS = bpe_pkg::NSTAGES;

    // Per-stage valid bits and load enables.
    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    // A stage loads when it is empty or its contents move on.
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: clamp t, form 1-t and the control points.
    bpe_pkg::t_order                     n1_order, r1_order;
    logic [bpe_pkg::T_W-1:0]             n1_t, r1_t, n1_s, r1_s;
    logic signed [bpe_pkg::PT_W-1:0]     n1_px [4];
    logic signed [bpe_pkg::PT_W-1:0]     n1_py [4];
    logic signed [bpe_pkg::PT_W-1:0]     r1_px [4];
    logic signed [bpe_pkg::PT_W-1:0]     r1_py [4];

    always_comb begin
        logic signed [bpe_pkg::PT_W-1:0] sx, sy, ex, ey;
        sx = bpe_pkg::PT_W'(i_in_word.start_x);
        sy = bpe_pkg::PT_W'(i_in_word.start_y);
        ex = bpe_pkg::PT_W'(i_in_word.end_x);
        ey = bpe_pkg::PT_W'(i_in_word.end_y);
        n1_t = (i_in_word.curve_param > bpe_pkg::T_ONE) ? bpe_pkg::T_ONE
                                                         : i_in_word.curve_param;
        n1_s = bpe_pkg::T_ONE - n1_t;
        n1_px[0] = sx;
        n1_py[0] = sy;
        n1_px[1] = sx + bpe_pkg::PT_W'(i_in_word.out_dx);
        n1_py[1] = sy + bpe_pkg::PT_W'(i_in_word.out_dy);
        n1_px[2] = ex + bpe_pkg::PT_W'(i_in_word.in_dx);
        n1_py[2] = ey + bpe_pkg::PT_W'(i_in_word.in_dy);
        n1_px[3] = ex;
        n1_py[3] = ey;
        unique case (i_in_word.command)
            bpe_pkg::CMD_LINEAR: begin
                n1_order = bpe_pkg::ORD_LINEAR;
                n1_px[1] = ex;
                n1_py[1] = ey;
            end
            bpe_pkg::CMD_QUAD: begin
                n1_order = bpe_pkg::ORD_QUAD;
                n1_px[2] = ex;
                n1_py[2] = ey;
            end
            bpe_pkg::CMD_CUBIC: begin
                n1_order = bpe_pkg::ORD_CUBIC;
            end
            default: begin
                // The unused order code is evaluated as a cubic.
                n1_order = bpe_pkg::ORD_CUBIC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_order <= n1_order;
            r1_t     <= n1_t;
            r1_s     <= n1_s;
            r1_px    <= n1_px;
            r1_py    <= n1_py;
        end
    end

    // Stage 2: squares and cross product of t and 1-t.
    bpe_pkg::t_order                     r2_order;
    logic [bpe_pkg::T_W-1:0]             r2_t, r2_s;
    logic [bpe_pkg::SQ_W-1:0]            r2_ss, r2_st, r2_tt;
    logic signed [bpe_pkg::PT_W-1:0]     r2_px [4];
    logic signed [bpe_pkg::PT_W-1:0]     r2_py [4];
    logic [2*bpe_pkg::T_W-1:0]           n2_ss, n2_st, n2_tt;

    assign n2_ss = r1_s * r1_s;
    assign n2_st = r1_s * r1_t;
    assign n2_tt = r1_t * r1_t;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_order <= r1_order;
            r2_t     <= r1_t;
            r2_s     <= r1_s;
            r2_ss    <= n2_ss[bpe_pkg::SQ_W-1:0];
            r2_st    <= n2_st[bpe_pkg::SQ_W-1:0];
            r2_tt    <= n2_tt[bpe_pkg::SQ_W-1:0];
            r2_px    <= r1_px;
            r2_py    <= r1_py;
        end
    end

    // Stage 3: cubic powers.
    bpe_pkg::t_order                     r3_order;
    logic [bpe_pkg::T_W-1:0]             r3_t, r3_s;
    logic [bpe_pkg::SQ_W-1:0]            r3_ss, r3_st, r3_tt;
    logic [bpe_pkg::CB_W-1:0]            r3_sss, r3_sst, r3_stt, r3_ttt;
    logic signed [bpe_pkg::PT_W-1:0]     r3_px [4];
    logic signed [bpe_pkg::PT_W-1:0]     r3_py [4];
    logic [bpe_pkg::SQ_W+bpe_pkg::T_W-1:0] n3_sss, n3_sst, n3_stt, n3_ttt;

    assign n3_sss = r2_ss * r2_s;
    assign n3_sst = r2_ss * r2_t;
    assign n3_stt = r2_tt * r2_s;
    assign n3_ttt = r2_tt * r2_t;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_order <= r2_order;
            r3_t     <= r2_t;
            r3_s     <= r2_s;
            r3_ss    <= r2_ss;
            r3_st    <= r2_st;
            r3_tt    <= r2_tt;
            r3_sss   <= n3_sss[bpe_pkg::CB_W-1:0];
            r3_sst   <= n3_sst[bpe_pkg::CB_W-1:0];
            r3_stt   <= n3_stt[bpe_pkg::CB_W-1:0];
            r3_ttt   <= n3_ttt[bpe_pkg::CB_W-1:0];
            r3_px    <= r2_px;
            r3_py    <= r2_py;
        end
    end

    // Stage 4: Bernstein weights, all scaled to the cubic fraction width.
    logic [bpe_pkg::W_W-1:0]             n4_w [4];
    logic [bpe_pkg::W_W-1:0]             r4_w [4];
    logic signed [bpe_pkg::PT_W-1:0]     r4_px [4];
    logic signed [bpe_pkg::PT_W-1:0]     r4_py [4];

    always_comb begin
        unique case (r3_order)
            bpe_pkg::ORD_LINEAR: begin
                n4_w[0] = bpe_pkg::W_W'(r3_s) << (2 * bpe_pkg::FRAC_BITS);
                n4_w[1] = bpe_pkg::W_W'(r3_t) << (2 * bpe_pkg::FRAC_BITS);
                n4_w[2] = '0;
                n4_w[3] = '0;
            end
            bpe_pkg::ORD_QUAD: begin
                n4_w[0] = bpe_pkg::W_W'(r3_ss) << bpe_pkg::FRAC_BITS;
                n4_w[1] = bpe_pkg::W_W'(r3_st) << (bpe_pkg::FRAC_BITS + 1);
                n4_w[2] = bpe_pkg::W_W'(r3_tt) << bpe_pkg::FRAC_BITS;
                n4_w[3] = '0;
            end
            bpe_pkg::ORD_CUBIC: begin
                n4_w[0] = r3_sss;
                n4_w[1] = r3_sst + bpe_pkg::W_W'({r3_sst, 1'b0});
                n4_w[2] = r3_stt + bpe_pkg::W_W'({r3_stt, 1'b0});
                n4_w[3] = r3_ttt;
            end
            default: begin
                // Only an empty slot can carry an unknown order.
                n4_w[0] = '0;
                n4_w[1] = '0;
                n4_w[2] = '0;
                n4_w[3] = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_w  <= n4_w;
            r4_px <= r3_px;
            r4_py <= r3_py;
        end
    end

    // Stage 5: each point times the low and high halves of its weight.
    logic signed [bpe_pkg::LO_PW-1:0]    n5_lx [4], n5_ly [4], r5_lx [4], r5_ly [4];
    logic signed [bpe_pkg::HI_PW-1:0]    n5_hx [4], n5_hy [4], r5_hx [4], r5_hy [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n5_lx[i] = r4_px[i] * $signed({1'b0, r4_w[i][bpe_pkg::W_LO-1:0]});
            n5_ly[i] = r4_py[i] * $signed({1'b0, r4_w[i][bpe_pkg::W_LO-1:0]});
            n5_hx[i] = r4_px[i] * $signed({1'b0, r4_w[i][bpe_pkg::W_W-1:bpe_pkg::W_LO]});
            n5_hy[i] = r4_py[i] * $signed({1'b0, r4_w[i][bpe_pkg::W_W-1:bpe_pkg::W_LO]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r5_lx <= n5_lx;
            r5_ly <= n5_ly;
            r5_hx <= n5_hx;
            r5_hy <= n5_hy;
        end
    end

    // Stage 6: recombine the halves into full terms.
    logic signed [bpe_pkg::TERM_W-1:0]   n6_tx [4], n6_ty [4], r6_tx [4], r6_ty [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n6_tx[i] = (bpe_pkg::TERM_W'(r5_hx[i]) <<< bpe_pkg::W_LO)
                       + bpe_pkg::TERM_W'(r5_lx[i]);
            n6_ty[i] = (bpe_pkg::TERM_W'(r5_hy[i]) <<< bpe_pkg::W_LO)
                       + bpe_pkg::TERM_W'(r5_ly[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r6_tx <= n6_tx;
            r6_ty <= n6_ty;
        end
    end

    // Stage 7: pairwise sums of the terms.
    logic signed [bpe_pkg::ACC_W-1:0]    r7_x01, r7_x23, r7_y01, r7_y23;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r7_x01 <= bpe_pkg::ACC_W'(r6_tx[0]) + bpe_pkg::ACC_W'(r6_tx[1]);
            r7_x23 <= bpe_pkg::ACC_W'(r6_tx[2]) + bpe_pkg::ACC_W'(r6_tx[3]);
            r7_y01 <= bpe_pkg::ACC_W'(r6_ty[0]) + bpe_pkg::ACC_W'(r6_ty[1]);
            r7_y23 <= bpe_pkg::ACC_W'(r6_ty[2]) + bpe_pkg::ACC_W'(r6_ty[3]);
        end
    end

    // Stage 8: final sum with the rounding half added.
    logic signed [bpe_pkg::ACC_W-1:0]    r8_ax, r8_ay;

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r8_ax <= r7_x01 + r7_x23 + bpe_pkg::ACC_HALF;
            r8_ay <= r7_y01 + r7_y23 + bpe_pkg::ACC_HALF;
        end
    end

    // Stage 9: drop the fraction bits and saturate to the coordinate range.
    bpe_pkg::t_out_word                  n9_out, r9_out;

    always_comb begin
        logic signed [bpe_pkg::RES_W-1:0] rx, ry;
        logic                             cx, cy;
        rx = $signed(r8_ax[bpe_pkg::ACC_W-1:bpe_pkg::SHIFT]);
        ry = $signed(r8_ay[bpe_pkg::ACC_W-1:bpe_pkg::SHIFT]);
        cx = 1'b1;
        cy = 1'b1;
        if (rx > bpe_pkg::RES_MAX) begin
            n9_out.point_x = bpe_pkg::COORD_W'(bpe_pkg::RES_MAX);
        end else if (rx < bpe_pkg::RES_MIN) begin
            n9_out.point_x = bpe_pkg::COORD_W'(bpe_pkg::RES_MIN);
        end else begin
            n9_out.point_x = bpe_pkg::COORD_W'(rx);
            cx = 1'b0;
        end
        if (ry > bpe_pkg::RES_MAX) begin
            n9_out.point_y = bpe_pkg::COORD_W'(bpe_pkg::RES_MAX);
        end else if (ry < bpe_pkg::RES_MIN) begin
            n9_out.point_y = bpe_pkg::COORD_W'(bpe_pkg::RES_MIN);
        end else begin
            n9_out.point_y = bpe_pkg::COORD_W'(ry);
            cy = 1'b0;
        end
        n9_out.clipped = cx | cy;
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r9_out <= n9_out;
        end
    end

    assign o_out_word = r9_out;

`ifndef SYNTHESIS
    // The clamped parameter never exceeds one.
    a_t_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r1_t <= bpe_pkg::T_ONE))
        else $error("clamped t above one");

    // The Bernstein weights of a valid word always sum to exactly one.
    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> ((bpe_pkg::W_W + 2)'(r4_w[0]) + (bpe_pkg::W_W + 2)'(r4_w[1])
                      + (bpe_pkg::W_W + 2)'(r4_w[2]) + (bpe_pkg::W_W + 2)'(r4_w[3])
                      == bpe_pkg::W_SUM))
        else $error("weights do not sum to one");

    // The input only stalls when the output holds a word that is not taken.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without an output stall");

    // An accepted word occupies the first stage on the next cycle.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted word lost at entry");
`endif

endmodule

[tb/bezier_point_eval_unit_tb.sv]
`timescale 1ns / 1ps

module bezier_point_eval_unit_tb;

    // Command value 3 has no name in the package; the block treats it as cubic.
    localparam logic [1:0] CMD_CUBIC_ALT = 2'd3;

    localparam logic signed [bpe_pkg::COORD_W-1:0] C_MAX =
        {1'b0, {(bpe_pkg::COORD_W-1){1'b1}}};
    localparam logic signed [bpe_pkg::COORD_W-1:0] C_MIN =
        {1'b1, {(bpe_pkg::COORD_W-1){1'b0}}};
    localparam logic [bpe_pkg::T_W-1:0] T_HALF = bpe_pkg::T_ONE >> 1;
    localparam logic [bpe_pkg::T_W-1:0] T_ALL  = {bpe_pkg::T_W{1'b1}};
    localparam logic [bpe_pkg::T_W-1:0] T_STEP = bpe_pkg::T_W'(1);

    localparam int RANDOM_WORDS = 650;
    localparam int LONG_HOLD    = 200;

    // Predicts each output word from the accepted input words and checks the
    // block's output words against them in order.
    class point_scoreboard;
        bpe_pkg::t_out_word pending_points[$];
        int                 fail_count = 0;

        // Exact Bernstein sum along one axis, rounded once to Q15.8.
        function logic signed [127:0] axis_sum(int order,
                                               logic signed [127:0] s_pos,
                                               logic signed [127:0] s_vec,
                                               logic signed [127:0] e_pos,
                                               logic signed [127:0] e_vec,
                                               logic signed [127:0] tt,
                                               logic signed [127:0] ss);
            logic signed [127:0] acc;
            int                  fbits;
            case (order)
                1: acc = s_pos * ss + e_pos * tt;
                2: acc = s_pos * ss * ss + 2 * (s_pos + s_vec) * tt * ss
                         + e_pos * tt * tt;
                default: acc = s_pos * ss * ss * ss + 3 * (s_pos + s_vec) * tt * ss * ss
                               + 3 * (e_pos + e_vec) * tt * tt * ss
                               + e_pos * tt * tt * tt;
            endcase
            fbits = order * bpe_pkg::FRAC_BITS;
            // Add half an output LSB, then floor: ties go toward plus infinity.
            return (acc + (128'sd1 <<< (fbits - 1))) >>> fbits;
        endfunction

        function logic signed [bpe_pkg::COORD_W-1:0] clamp_coord(
                logic signed [127:0] v, output bit clip);
            logic signed [127:0] hi;
            logic signed [127:0] lo;
            hi   = C_MAX;
            lo   = C_MIN;
            clip = 1'b0;
            if (v > hi) begin
                clip = 1'b1;
                return C_MAX;
            end
            if (v < lo) begin
                clip = 1'b1;
                return C_MIN;
            end
            return v[bpe_pkg::COORD_W-1:0];
        endfunction

        function bpe_pkg::t_out_word eval_point(bpe_pkg::t_in_word w);
            int                  order;
            logic signed [127:0] tt;
            logic signed [127:0] ss;
            bit                  cx;
            bit                  cy;
            bpe_pkg::t_out_word  res;
            case (w.command)
                bpe_pkg::CMD_LINEAR: order = 1;
                bpe_pkg::CMD_QUAD:   order = 2;
                default:             order = 3;
            endcase
            // A parameter above one is taken as exactly one.
            tt = (w.curve_param > bpe_pkg::T_ONE) ? 128'(bpe_pkg::T_ONE)
                                                  : 128'(w.curve_param);
            ss = 128'(bpe_pkg::T_ONE) - tt;
            res.point_x = clamp_coord(axis_sum(order, w.start_x, w.out_dx, w.end_x,
                                               w.in_dx, tt, ss), cx);
            res.point_y = clamp_coord(axis_sum(order, w.start_y, w.out_dy, w.end_y,
                                               w.in_dy, tt, ss), cy);
            res.clipped = cx | cy;
            return res;
        endfunction

        function void note_segment(bpe_pkg::t_in_word w);
            pending_points = {pending_points, eval_point(w)};
        endfunction

        function void check_point(bpe_pkg::t_out_word got);
            bpe_pkg::t_out_word want;
            if (pending_points.size() == 0) begin
                $error("output word with no pending expectation: x %0d y %0d clipped %0b",
                       got.point_x, got.point_y, got.clipped);
                fail_count++;
                return;
            end
            want = pending_points.pop_front();
            if (got.point_x !== want.point_x) begin
                $error("point_x mismatch: expected %0d, got %0d", want.point_x, got.point_x);
                fail_count++;
            end
            if (got.point_y !== want.point_y) begin
                $error("point_y mismatch: expected %0d, got %0d", want.point_y, got.point_y);
                fail_count++;
            end
            if (got.clipped !== want.clipped) begin
                $error("clipped mismatch: expected %0b, got %0b", want.clipped, got.clipped);
                fail_count++;
            end
        endfunction

        function int outstanding();
            return pending_points.size();
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    bpe_pkg::t_in_word  in_word   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    bpe_pkg::t_out_word out_word;

    // Shared between the stimulus and the output-side process.
    bit hold_req = 1'b0;
    bit steady   = 1'b0;

    // Directed words, sent before the random ones.
    bpe_pkg::t_in_word directed_words[$];

    point_scoreboard board = new();

    bezier_point_eval_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Runaway guard.
    initial begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

    // Watch both handshakes at every edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                board.note_segment(in_word);
            end
            if (out_valid && out_ready) begin
                board.check_point(out_word);
            end
        end
    end

    // Output side: random stalls, a quiet stretch when asked, and one long hold.
    initial begin
        int r;
        int len;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (steady) begin
                out_ready <= 1'b1;
                @(posedge clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    len = $urandom_range(1, 8);
                    out_ready <= 1'b1;
                end else if (r < 92) begin
                    len = $urandom_range(1, 3);
                    out_ready <= 1'b0;
                end else begin
                    len = $urandom_range(10, 40);
                    out_ready <= 1'b0;
                end
                repeat (len) @(posedge clk);
            end
        end
    end

    function automatic bpe_pkg::t_in_word make_word(
            logic [1:0] cmd,
            logic signed [bpe_pkg::COORD_W-1:0] sx,
            logic signed [bpe_pkg::COORD_W-1:0] sy,
            logic signed [bpe_pkg::COORD_W-1:0] ex,
            logic signed [bpe_pkg::COORD_W-1:0] ey,
            logic signed [bpe_pkg::COORD_W-1:0] ox,
            logic signed [bpe_pkg::COORD_W-1:0] oy,
            logic signed [bpe_pkg::COORD_W-1:0] ix,
            logic signed [bpe_pkg::COORD_W-1:0] iy,
            logic [bpe_pkg::T_W-1:0] t);
        bpe_pkg::t_in_word w;
        w.command     = cmd;
        w.start_x     = sx;
        w.start_y     = sy;
        w.end_x       = ex;
        w.end_y       = ey;
        w.out_dx      = ox;
        w.out_dy      = oy;
        w.in_dx       = ix;
        w.in_dy       = iy;
        w.curve_param = t;
        return w;
    endfunction

    function automatic void add_directed(bpe_pkg::t_in_word w);
        directed_words = {directed_words, w};
    endfunction

    // Coordinates: mostly full range, with extremes and small values mixed in.
    function automatic logic signed [bpe_pkg::COORD_W-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return C_MAX;
            1:       return C_MIN;
            2, 3, 4: return bpe_pkg::COORD_W'($signed($urandom_range(0, 8192)) - 4096);
            default: return bpe_pkg::COORD_W'($urandom);
        endcase
    endfunction

    function automatic bpe_pkg::t_in_word rand_segment();
        bpe_pkg::t_in_word w;
        int                r;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            w.command = bpe_pkg::CMD_LINEAR;
        end else if (r < 6) begin
            w.command = bpe_pkg::CMD_QUAD;
        end else if (r < 9) begin
            w.command = bpe_pkg::CMD_CUBIC;
        end else begin
            w.command = CMD_CUBIC_ALT;
        end
        w.start_x = rand_coord();
        w.start_y = rand_coord();
        w.end_x   = rand_coord();
        w.end_y   = rand_coord();
        w.out_dx  = rand_coord();
        w.out_dy  = rand_coord();
        w.in_dx   = rand_coord();
        w.in_dy   = rand_coord();
        r = $urandom_range(0, 99);
        if (r < 70) begin
            w.curve_param = bpe_pkg::T_W'($urandom_range(0, bpe_pkg::T_ONE));
        end else if (r < 80) begin
            w.curve_param = ($urandom_range(0, 1) != 0) ? bpe_pkg::T_ONE : '0;
        end else if (r < 90) begin
            w.curve_param = bpe_pkg::T_W'($urandom_range(bpe_pkg::T_ONE + 1, T_ALL));
        end else begin
            w.curve_param = bpe_pkg::T_W'($urandom);
        end
        return w;
    endfunction

    // Mostly back to back, sometimes short gaps, rarely long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Offer one word and return at the edge where it is taken.
    task automatic send_segment(input bpe_pkg::t_in_word w, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both endpoints of t and mid t, with unused vectors set to garbage at the endpoints.
        add_directed(make_word(bpe_pkg::CMD_LINEAR, C_MAX, C_MIN, C_MIN, C_MAX,
                               C_MAX, C_MIN, C_MIN, C_MAX, '0));
        add_directed(make_word(bpe_pkg::CMD_LINEAR, C_MAX, C_MIN, C_MIN, C_MAX,
                               C_MIN, C_MAX, C_MAX, C_MIN, bpe_pkg::T_ONE));
        add_directed(make_word(bpe_pkg::CMD_LINEAR, 24'sd1000, -24'sd1000, 24'sd3000,
                               24'sd77, '0, '0, '0, '0, T_HALF));
        // Quadratic and cubic at mid parameter, the spare cubic code at a quarter; quadratic ignores the in vector.
        add_directed(make_word(bpe_pkg::CMD_QUAD, -24'sd5000, 24'sd2000, 24'sd7000,
                               -24'sd9000, 24'sd12345, -24'sd4321, C_MAX, C_MIN,
                               T_HALF));
        add_directed(make_word(bpe_pkg::CMD_CUBIC, -24'sd5000, 24'sd2000, 24'sd7000,
                               -24'sd9000, 24'sd12345, -24'sd4321, -24'sd777,
                               24'sd888, T_HALF));
        add_directed(make_word(CMD_CUBIC_ALT, -24'sd5000, 24'sd2000, 24'sd7000,
                               -24'sd9000, 24'sd12345, -24'sd4321, -24'sd777,
                               24'sd888, 17'h4000));
        // Parameter beyond one.
        add_directed(make_word(bpe_pkg::CMD_CUBIC, 24'sd100, 24'sd200, 24'sd300,
                               24'sd400, 24'sd500, 24'sd600, 24'sd700, 24'sd800,
                               bpe_pkg::T_ONE + T_STEP));
        add_directed(make_word(bpe_pkg::CMD_QUAD, 24'sd100, 24'sd200, 24'sd300,
                               24'sd400, 24'sd500, 24'sd600, 24'sd700, 24'sd800,
                               T_ALL));
        // Saturation high and low, and one axis only.
        add_directed(make_word(bpe_pkg::CMD_QUAD, C_MAX, C_MAX, C_MAX, C_MAX,
                               C_MAX, C_MAX, C_MAX, C_MAX, T_HALF));
        add_directed(make_word(bpe_pkg::CMD_CUBIC, C_MIN, C_MIN, C_MIN, C_MIN,
                               C_MIN, C_MIN, C_MIN, C_MIN, T_HALF));
        add_directed(make_word(bpe_pkg::CMD_CUBIC, C_MAX, '0, C_MAX, '0,
                               C_MAX, '0, C_MAX, '0, 17'h8001));
        add_directed(make_word(bpe_pkg::CMD_CUBIC, '0, C_MIN, '0, C_MIN,
                               '0, C_MIN, '0, C_MIN, 17'h0001));
        // All zero.
        add_directed(make_word(bpe_pkg::CMD_LINEAR, '0, '0, '0, '0,
                               '0, '0, '0, '0, '0));
        // Rounding ties go up: +0.5 LSB becomes 1, -0.5 LSB becomes 0.
        add_directed(make_word(bpe_pkg::CMD_LINEAR, '0, '0, 24'sd1, -24'sd1,
                               '0, '0, '0, '0, T_HALF));
        add_directed(make_word(bpe_pkg::CMD_QUAD, '0, '0, '0, '0,
                               24'sd1, -24'sd1, '0, '0, T_HALF));
        // Huge vectors with weights that are exactly zero at the ends.
        add_directed(make_word(bpe_pkg::CMD_CUBIC, 24'sd42, -24'sd42, 24'sd99, -24'sd99,
                               C_MAX, C_MIN, C_MIN, C_MAX, bpe_pkg::T_ONE));
        add_directed(make_word(bpe_pkg::CMD_CUBIC, 24'sd42, -24'sd42, 24'sd99, -24'sd99,
                               C_MIN, C_MAX, C_MAX, C_MIN, '0));
        // Smallest step of t away from each end.
        add_directed(make_word(bpe_pkg::CMD_CUBIC, C_MIN, C_MAX, C_MAX, C_MIN,
                               24'sd3, -24'sd3, 24'sd5, -24'sd5, 17'h0001));
        add_directed(make_word(bpe_pkg::CMD_QUAD, C_MIN, C_MAX, C_MAX, C_MIN,
                               24'sd3, -24'sd3, 24'sd5, -24'sd5,
                               bpe_pkg::T_ONE - T_STEP));

        foreach (directed_words[i]) begin
            send_segment(directed_words[i], gap_len());
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // A stretch with no idling, and a long output hold that backs up
            // the pipeline while words keep being offered.
            if (n == 200) begin
                steady = 1'b1;
            end
            if (n == 300) begin
                hold_req = 1'b1;
            end
            if (n == 350) begin
                steady = 1'b0;
            end
            send_segment(rand_segment(), steady ? 0 : gap_len());
        end
        in_valid <= 1'b0;

        // Let the monitor note the last accepted word before draining.
        @(posedge clk);
        while (board.outstanding() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (board.fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/bpe_pkg.sv
hdl/bezier_point_eval_unit.sv
tb/bezier_point_eval_unit_tb.sv
